### rtl/interval_room_allocator_macros.svh
// Assertion macros for the interval room allocator checker.
// Depends on nothing; included by the checker file only.
`ifndef INTERVAL_ROOM_ALLOCATOR_MACROS_SVH
`define INTERVAL_ROOM_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define IRA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ira check failed");

// next-cycle implication, disabled during reset
`define IRA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ira check failed");

`endif

### rtl/ira_pkg.sv
// Shared types and constants of the interval room allocator.
// Depends on nothing; used by every module of the block but the RAM.
package ira_pkg;

  localparam int MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic [31:0] start_day;
    logic [31:0] end_day;
    logic        last;
  } ira_in_t;

  typedef struct packed {
    logic [5:0] item_index;
    logic [6:0] room;
    logic [6:0] room_count;
    logic       last_result;
  } ira_out_t;

  // control from the sequencer to the cells
  typedef struct packed {
    logic insert;
    logic drain;
  } ira_sort_ctl_t;

  typedef struct packed {
    logic expire;
    logic clear;
  } ira_room_ctl_t;

endpackage

### rtl/ira_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module ira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/ira_sort_cell.sv
// One cell of the sorted insertion chain: holds one interval and its load index.
// Depends on ira_pkg.
module ira_sort_cell
  import ira_pkg::*;
#(
  parameter int IW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  ira_sort_ctl_t ctl,
  input  logic [31:0]   new_start,
  input  logic [31:0]   new_end,
  input  logic [IW-1:0] new_idx,
  input  logic          prev_valid,
  input  logic          prev_lt,
  input  logic [31:0]   prev_start,
  input  logic [31:0]   prev_end,
  input  logic [IW-1:0] prev_idx,
  input  logic          nxt_valid,
  input  logic [31:0]   nxt_start,
  input  logic [31:0]   nxt_end,
  input  logic [IW-1:0] nxt_idx,
  output logic          valid,
  output logic          lt,
  output logic [31:0]   c_start,
  output logic [31:0]   c_end,
  output logic [IW-1:0] c_idx
);
  // the new item goes before an equal pair since it was loaded later
  assign lt = !valid || (new_start < c_start) ||
              ((new_start == c_start) && (new_end <= c_end));

  // shift in from the previous cell when the new item lands at or before it;
  // an empty previous cell keeps this one empty; a drain shifts in from the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.drain) begin
      valid <= nxt_valid;
    end else if (ctl.insert && lt) begin
      valid <= prev_lt ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      c_start <= nxt_start;
      c_end   <= nxt_end;
      c_idx   <= nxt_idx;
    end else if (ctl.insert && lt) begin
      if (prev_lt) begin
        c_start <= prev_start;
        c_end   <= prev_end;
        c_idx   <= prev_idx;
      end else begin
        c_start <= new_start;
        c_end   <= new_end;
        c_idx   <= new_idx;
      end
    end
  end
endmodule

### rtl/ira_room_cell.sv
// One room cell: occupancy flag and last booked day of one room.
// Depends on ira_pkg.
module ira_room_cell
  import ira_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  ira_room_ctl_t ctl,
  input  logic [31:0]   head_start,
  input  logic          take,
  input  logic [31:0]   take_end,
  output logic          in_use
);
  logic [31:0] busy_until;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      in_use <= 1'b0;
    end else if (take) begin
      in_use <= 1'b1;
    end else if (ctl.expire && (busy_until < head_start)) begin
      in_use <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      busy_until <= take_end;
    end
  end
endmodule

### rtl/interval_room_allocator.sv
// Interval room allocator: loads one interval per cycle (start && !busy), sorted on entry.
// After the transfer marked last: each interval is allocated by a free step, then a pick step,
// then one result per cycle in load order, the first in the cycle after output starts.
// The receiver cannot stall.
// Synchronous active-high reset clears the cells, counters and sequencer.
module interval_room_allocator
  import ira_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  ira_in_t  in_item,
  output logic     busy,
  output logic     result_valid,
  output ira_out_t result
);
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_FREE = 5'b00010,
    ST_PICK = 5'b00100,
    ST_OUT  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] created;
  logic [IW-1:0] out_k;
  logic [IW-1:0] res_idx;
  logic          res_last;
  logic          rd_pend;

  logic          accept;
  ira_sort_ctl_t sort_ctl;
  ira_room_ctl_t room_ctl;

  // chain wiring, one slot per cell
  logic          s_valid [MAX_ITEMS];
  logic          s_lt    [MAX_ITEMS];
  logic [31:0]   s_start [MAX_ITEMS];
  logic [31:0]   s_end   [MAX_ITEMS];
  logic [IW-1:0] s_idx   [MAX_ITEMS];

  logic [MAX_ITEMS-1:0] in_use;
  logic [MAX_ITEMS-1:0] take;
  logic [IW-1:0]        pick_room;
  logic [IW-1:0]        ram_rdata;

  assign busy   = (state != ST_LOAD);
  assign accept = start && !busy;

  // insert only while the store has room; a dropped item can still close the set
  assign sort_ctl.insert = accept && (count < CW'(MAX_ITEMS));
  assign sort_ctl.drain  = (state == ST_PICK);
  assign room_ctl.expire = (state == ST_FREE);
  assign room_ctl.clear  = (state == ST_FIN);

  // lowest free room; rooms past the created count are always free
  always_comb begin
    pick_room = '0;
    for (int j = MAX_ITEMS - 1; j >= 0; j--) begin
      if (!in_use[j]) begin
        pick_room = IW'(j);
      end
    end
  end

  always_comb begin
    take = '0;
    if (state == ST_PICK) begin
      take[pick_room] = 1'b1;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
      logic          p_valid, p_lt, n_valid;
      logic [31:0]   p_start, p_end, n_start, n_end;
      logic [IW-1:0] p_idx, n_idx;

      if (g == 0) begin : g_first
        assign p_valid = 1'b0;
        assign p_lt    = 1'b0;
        assign p_start = '0;
        assign p_end   = '0;
        assign p_idx   = '0;
      end else begin : g_mid
        assign p_valid = s_valid[g-1];
        assign p_lt    = s_lt[g-1];
        assign p_start = s_start[g-1];
        assign p_end   = s_end[g-1];
        assign p_idx   = s_idx[g-1];
      end

      if (g == MAX_ITEMS - 1) begin : g_tail
        assign n_valid = 1'b0;
        assign n_start = '0;
        assign n_end   = '0;
        assign n_idx   = '0;
      end else begin : g_body
        assign n_valid = s_valid[g+1];
        assign n_start = s_start[g+1];
        assign n_end   = s_end[g+1];
        assign n_idx   = s_idx[g+1];
      end

      ira_sort_cell #(.IW(IW)) u_sort (
        .clk       (clk),
        .rst       (rst),
        .ctl       (sort_ctl),
        .new_start (in_item.start_day),
        .new_end   (in_item.end_day),
        .new_idx   (count[IW-1:0]),
        .prev_valid(p_valid),
        .prev_lt   (p_lt),
        .prev_start(p_start),
        .prev_end  (p_end),
        .prev_idx  (p_idx),
        .nxt_valid (n_valid),
        .nxt_start (n_start),
        .nxt_end   (n_end),
        .nxt_idx   (n_idx),
        .valid     (s_valid[g]),
        .lt        (s_lt[g]),
        .c_start   (s_start[g]),
        .c_end     (s_end[g]),
        .c_idx     (s_idx[g])
      );

      ira_room_cell u_room (
        .clk       (clk),
        .rst       (rst),
        .ctl       (room_ctl),
        .head_start(s_start[0]),
        .take      (take[g]),
        .take_end  (s_end[0]),
        .in_use    (in_use[g])
      );
    end
  endgenerate

  // room of each interval, written at its load index, read back in load order
  ira_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_assign_ram (
    .clk  (clk),
    .we   (state == ST_PICK),
    .waddr(s_idx[0]),
    .wdata(pick_room),
    .raddr(out_k),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: if (accept && in_item.last) state_next = ST_FREE;
      ST_FREE: state_next = ST_PICK;
      // advance to output once the last sorted interval leaves the head
      ST_PICK: state_next = s_valid[1] ? ST_FREE : ST_OUT;
      ST_OUT:  if ((CW'(out_k) + 1'b1) == count) state_next = ST_FIN;
      ST_FIN:  state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      created <= '0;
      out_k   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_OUT);
      if (sort_ctl.insert) begin
        count <= count + 1'b1;
      end
      if ((state == ST_PICK) && (CW'(pick_room) == created)) begin
        created <= created + 1'b1;
      end
      if (state == ST_OUT) begin
        out_k <= out_k + 1'b1;
      end
      // drop the finished set and return to loading
      if (state == ST_FIN) begin
        count   <= '0;
        created <= '0;
        out_k   <= '0;
      end
    end
  end

  // hold the index and last flag alongside the registered RAM read
  always_ff @(posedge clk) begin
    res_idx  <= out_k;
    res_last <= (CW'(out_k) + 1'b1) == count;
  end

  assign result_valid       = rd_pend;
  assign result.item_index  = 6'(res_idx);
  assign result.room        = 7'({1'b0, ram_rdata} + 1'b1);
  assign result.room_count  = 7'(created);
  assign result.last_result = res_last;
endmodule

### rtl/ira_checker.sv
// Port-level checker for the interval room allocator, bound to the top level.
// Depends on ira_pkg and interval_room_allocator_macros.svh.
`include "interval_room_allocator_macros.svh"
module ira_checker
  import ira_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input ira_in_t  in_item,
  input logic     busy,
  input logic     result_valid,
  input ira_out_t result
);
  `IRA_ASSERT_IMP(a_res_busy, clk, rst, result_valid, busy)
  `IRA_ASSERT_IMP(a_room_range, clk, rst, result_valid,
                  (result.room != 7'd0) && (result.room <= result.room_count))
  `IRA_ASSERT_NXT(a_last_ends, clk, rst, result_valid && result.last_result, !result_valid)
  `IRA_ASSERT_NXT(a_close, clk, rst, start && !busy && in_item.last, busy)
endmodule

bind interval_room_allocator ira_checker u_ira_checker (.*);

### sim/interval_room_allocator_checker.sv
// Checker for the interval room allocator: watches input and result transfers,
// predicts room assignments per closed set and compares. Depends on ira_pkg.
`timescale 1ns / 1ps

module interval_room_allocator_checker
  import ira_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  ira_in_t  in_item,
  input  logic     result_valid,
  input  ira_out_t result,
  output int       fail_count,
  output int       pending_rooms
);

  logic [31:0] stay_first [MAX_ITEMS];
  logic [31:0] stay_last [MAX_ITEMS];
  int          stays_held;
  ira_out_t    room_plan_q[$];

  // Sort the closed set and assign rooms, then queue one result per stay.
  task automatic plan_rooms();
    int          order [MAX_ITEMS];
    logic [31:0] busy_until [MAX_ITEMS];
    bit          occupied [MAX_ITEMS];
    int          room_of [MAX_ITEMS];
    int          opened;
    int          best;
    int          pick;
    int          tmp;
    int          a;
    int          b;
    bit          ahead;
    ira_out_t    r;
    opened = 0;
    for (int i = 0; i < stays_held; i++) order[i] = i;
    for (int i = 0; i < stays_held; i++) begin
      best = i;
      for (int j = i + 1; j < stays_held; j++) begin
        a = order[j];
        b = order[best];
        if (stay_first[a] != stay_first[b]) ahead = stay_first[a] < stay_first[b];
        else if (stay_last[a] != stay_last[b]) ahead = stay_last[a] < stay_last[b];
        else ahead = a > b;
        if (ahead) best = j;
      end
      tmp = order[i];
      order[i] = order[best];
      order[best] = tmp;
    end
    for (int i = 0; i < MAX_ITEMS; i++) occupied[i] = 0;
    for (int i = 0; i < stays_held; i++) begin
      a = order[i];
      pick = opened;
      for (int j = 0; j < opened; j++)
        if (occupied[j] && busy_until[j] < stay_first[a]) occupied[j] = 0;
      for (int j = opened - 1; j >= 0; j--)
        if (!occupied[j]) pick = j;
      if (pick == opened && opened < MAX_ITEMS) opened++;
      occupied[pick] = 1;
      busy_until[pick] = stay_last[a];
      room_of[a] = pick;
    end
    for (int k = 0; k < stays_held; k++) begin
      r.item_index  = 6'(k);
      r.room        = 7'(room_of[k] + 1);
      r.room_count  = 7'(opened);
      r.last_result = (k == stays_held - 1);
      room_plan_q = {room_plan_q, r};
    end
    stays_held = 0;
  endtask

  always @(posedge clk) begin
    ira_out_t want;
    if (rst) begin
      stays_held = 0;
      fail_count = 0;
      room_plan_q.delete();
    end else begin
      // check results before planning so a set closing this edge cannot mix in
      if (result_valid) begin
        if (room_plan_q.size() == 0) begin
          $error("unexpected result item_index=%0d", result.item_index);
          fail_count++;
        end else begin
          want = room_plan_q.pop_front();
          if (result.item_index !== want.item_index) begin
            $error("item_index exp %0d got %0d", want.item_index, result.item_index);
            fail_count++;
          end
          if (result.room !== want.room) begin
            $error("room exp %0d got %0d", want.room, result.room);
            fail_count++;
          end
          if (result.room_count !== want.room_count) begin
            $error("room_count exp %0d got %0d", want.room_count, result.room_count);
            fail_count++;
          end
          if (result.last_result !== want.last_result) begin
            $error("last_result exp %0d got %0d", want.last_result, result.last_result);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        // drop stays once the store is full
        if (stays_held < MAX_ITEMS) begin
          stay_first[stays_held] = in_item.start_day;
          stay_last[stays_held]  = in_item.end_day;
          stays_held++;
        end
        if (in_item.last) plan_rooms();
      end
    end
    pending_rooms = room_plan_q.size();
  end

endmodule

### sim/interval_room_allocator_tb.sv
// Testbench top for the interval room allocator: drives interval sets with
// random gaps and gives the verdict. Depends on ira_pkg, the allocator and the checker.
`timescale 1ns / 1ps

module interval_room_allocator_tb;
  import ira_pkg::*;

  localparam int DEPTH = MAX_ITEMS_DEF;

  logic     clk = 0;
  logic     rst = 1;
  logic     start = 0;
  ira_in_t  in_item = '0;
  logic     busy;
  logic     result_valid;
  ira_out_t result;
  int       fail_count;
  int       pending_rooms;
  int       sent;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  interval_room_allocator u_dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .result_valid(result_valid), .result(result)
  );

  interval_room_allocator_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .result_valid(result_valid), .result(result),
    .fail_count(fail_count), .pending_rooms(pending_rooms)
  );

  // Offer one interval, hold it until the transfer, then drop start for
  // a random gap. With no gap, start stays high into the next item.
  task automatic send_stay(input logic [31:0] first_day, input logic [31:0] last_day,
                           input logic close_set);
    int gap;
    gap = $urandom_range(0, 3);
    in_item <= '{start_day: first_day, end_day: last_day, last: close_set};
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait out a closed set: every result in, then a short settle.
  task automatic drain_set();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_rooms > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One random set; small day ranges in most sets make overlaps and ties common.
  task automatic random_set(input int count);
    logic [31:0] base;
    logic [31:0] s;
    logic [31:0] e;
    int          span;
    span = $urandom_range(0, 3);
    base = (span == 3) ? $urandom : $urandom_range(0, 40);
    for (int i = 0; i < count; i++) begin
      if (span == 3) begin
        s = $urandom;
        e = ($urandom_range(0, 7) == 0) ? $urandom : s + $urandom_range(0, 1000);
      end else begin
        s = base + $urandom_range(0, 12 << span);
        // occasionally reversed interval, handled as given
        e = ($urandom_range(0, 15) == 0) ? s - $urandom_range(0, 5)
                                          : s + $urandom_range(0, 8 << span);
      end
      send_stay(s, e, i == count - 1);
    end
    drain_set();
  endtask

  initial begin
    sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single interval closing its own set
    send_stay(32'd5, 32'd5, 1'b1);
    drain_set();
    // field extremes, identical pairs, touching days, reversed interval
    send_stay(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_stay(32'd0, 32'd0, 1'b0);
    send_stay(32'd0, 32'd0, 1'b0);
    send_stay(32'd1, 32'd3, 1'b0);
    send_stay(32'd3, 32'd4, 1'b0);
    send_stay(32'd4, 32'd9, 1'b0);
    send_stay(32'd10, 32'd2, 1'b0);
    send_stay(32'd0, 32'hFFFF_FFFF, 1'b0);
    send_stay(32'hAAAA_5555, 32'h5555_AAAA, 1'b1);
    drain_set();
    // many rooms freed at once by a late interval
    for (int i = 0; i < 5; i++) send_stay(32'd1, 32'd2, 1'b0);
    send_stay(32'd20, 32'd21, 1'b1);
    drain_set();

    // random sets; one overfills the store so excess items are dropped
    random_set(DEPTH + 3);
    random_set(DEPTH);
    while (sent < 410) random_set($urandom_range(1, 12));

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
